@@ src/lod_detail_interpolator_defines.svh @@
// assertion macros used by the lod detail interpolator
// no dependencies
`ifndef LOD_DETAIL_INTERPOLATOR_DEFINES_SVH
`define LOD_DETAIL_INTERPOLATOR_DEFINES_SVH
// implication checked on every edge outside reset
`define LOD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LOD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ src/lod_pkg.sv @@
// types and constants of the lod detail interpolator
// no dependencies
package lod_pkg;
	localparam int DistW = 24;
	localparam int FactW = 16;
	localparam int SqW = 50;
	localparam int RootSteps = 25;
	localparam int RootPerStage = 5;
	localparam int RootStages = 5;
	localparam int DivW = 25;
	localparam int NumW = 42;
	localparam logic [DistW-1:0] DistMax = '1;
	localparam logic [2:0] RegNearThr = 3'd0;
	localparam logic [2:0] RegNearFac = 3'd1;
	localparam logic [2:0] RegMidThr = 3'd2;
	localparam logic [2:0] RegMidFac = 3'd3;
	localparam logic [2:0] RegFarThr = 3'd4;
	localparam logic [2:0] RegFarFac = 3'd5;
	localparam logic [1:0] BandNear = 2'd0;
	localparam logic [1:0] BandLoMid = 2'd1;
	localparam logic [1:0] BandMidFar = 2'd2;
	localparam logic [1:0] BandBeyond = 2'd3;

	typedef struct packed {
		logic [DistW-1:0] near_thr;
		logic [FactW-1:0] near_fac;
		logic [DistW-1:0] mid_thr;
		logic [FactW-1:0] mid_fac;
		logic [DistW-1:0] far_thr;
		logic [FactW-1:0] far_fac;
	} cfg_t;

	// isqrt state: remainder and partial root
	typedef struct packed {
		logic [SqW+1:0] rem;
		logic [DistW:0] root;
	} sqrt_t;
endpackage

@@ src/lod_dist.sv @@
// distance unit: absolute differences, squares, sum, pipelined integer root
// depends on lod_pkg
module lod_dist #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic en,
	input  logic [COORD_WIDTH-1:0] ax [3],
	input  logic [COORD_WIDTH-1:0] bx [3],
	output logic [lod_pkg::DistW-1:0] dist_val
);
	localparam int W = lod_pkg::DistW;
	localparam int DW = COORD_WIDTH + 1;
	logic [W-1:0] diff_s1 [3];
	logic [2*W-1:0] sq_s2 [3];
	logic [lod_pkg::SqW-1:0] sum_s3;
	lod_pkg::sqrt_t rs_s [lod_pkg::RootStages+1];

	always_comb begin
		rs_s[0].rem = {2'b00, sum_s3};
		rs_s[0].root = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [DW-1:0] d;
				logic [DW-1:0] m;
				d = DW'($signed(ax[i])) - DW'($signed(bx[i]));
				m = d[DW-1] ? DW'(-d) : DW'(d);
				diff_s1[i] <= (m > DW'(lod_pkg::DistMax)) ? lod_pkg::DistMax : W'(m);
				sq_s2[i] <= (2*W)'(diff_s1[i]) * (2*W)'(diff_s1[i]);
			end
			sum_s3 <= lod_pkg::SqW'(sq_s2[0]) + lod_pkg::SqW'(sq_s2[1])
				+ lod_pkg::SqW'(sq_s2[2]);
		end
	end

	// digit-by-digit root, five digits per stage
	for (genvar g = 0; g < lod_pkg::RootStages; g++) begin : g_root
		lod_pkg::sqrt_t nxt;
		always_comb begin
			nxt = rs_s[g];
			for (int k = 0; k < lod_pkg::RootPerStage; k++) begin
				int unsigned sh;
				logic [lod_pkg::SqW+1:0] trial;
				logic [lod_pkg::SqW+1:0] top;
				sh = 2 * (lod_pkg::RootSteps - 1 - (g * lod_pkg::RootPerStage + k));
				top = nxt.rem >> sh;
				trial = {(lod_pkg::SqW - W + 1)'(0), nxt.root} << 2 | 52'd1;
				nxt.root = nxt.root << 1;
				if (top >= trial) begin
					nxt.rem = nxt.rem - (trial << sh);
					nxt.root[0] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) rs_s[g+1] <= nxt;
		end
	end

	assign dist_val = (rs_s[lod_pkg::RootStages].root > {1'b0, lod_pkg::DistMax}) ?
		lod_pkg::DistMax : rs_s[lod_pkg::RootStages].root[W-1:0];
endmodule

@@ src/lod_lerp.sv @@
// band select, interpolation numerator and pipelined restoring divider
// depends on lod_pkg
module lod_lerp (
	input  logic clk,
	input  logic en,
	input  lod_pkg::cfg_t cfg,
	input  logic [lod_pkg::DistW-1:0] dist_val,
	output logic [lod_pkg::FactW-1:0] level,
	output logic [lod_pkg::DistW-1:0] dist_out,
	output logic [1:0] band
);
	localparam int W = lod_pkg::DistW;
	localparam int NW = lod_pkg::NumW;
	localparam int QW = 17;
	localparam int DStages = 4;
	localparam int BitsPer = (QW + DStages - 1) / DStages;

	logic [W-1:0] d_s1, lo_s1, hi_s1;
	logic [lod_pkg::FactW-1:0] a_s1, b_s1;
	logic [1:0] band_s1;
	logic [NW-1:0] pa_s2, pb_s2;
	logic [W-1:0] span_s2, d_s2;
	logic [lod_pkg::FactW-1:0] a_s2;
	logic [1:0] band_s2;
	logic [NW-1:0] num_s3;
	logic [W-1:0] span_s3, d_s3;
	logic [lod_pkg::FactW-1:0] a_s3;
	logic [1:0] band_s3;
	logic [NW-1:0] rem_q [DStages+1];
	logic [QW-1:0] quo_q [DStages+1];
	logic [W-1:0] span_q [DStages+1];
	logic [W-1:0] dd_q [DStages+1];
	logic [lod_pkg::FactW-1:0] aa_q [DStages+1];
	logic [1:0] bb_q [DStages+1];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= dist_val;
			if (dist_val <= cfg.near_thr) begin
				band_s1 <= lod_pkg::BandNear;
				a_s1 <= cfg.near_fac; b_s1 <= cfg.near_fac;
				lo_s1 <= dist_val; hi_s1 <= dist_val + W'(1);
			end else if (dist_val <= cfg.mid_thr) begin
				band_s1 <= lod_pkg::BandLoMid;
				a_s1 <= cfg.near_fac; b_s1 <= cfg.mid_fac;
				lo_s1 <= cfg.near_thr; hi_s1 <= cfg.mid_thr;
			end else if (dist_val <= cfg.far_thr) begin
				band_s1 <= lod_pkg::BandMidFar;
				a_s1 <= cfg.mid_fac; b_s1 <= cfg.far_fac;
				lo_s1 <= cfg.mid_thr; hi_s1 <= cfg.far_thr;
			end else begin
				band_s1 <= lod_pkg::BandBeyond;
				a_s1 <= cfg.far_fac >> 1; b_s1 <= cfg.far_fac >> 1;
				lo_s1 <= dist_val; hi_s1 <= dist_val + W'(1);
			end
			pa_s2 <= NW'(a_s1) * NW'(hi_s1 - d_s1);
			pb_s2 <= NW'(b_s1) * NW'(d_s1 - lo_s1);
			span_s2 <= hi_s1 - lo_s1;
			d_s2 <= d_s1; a_s2 <= a_s1; band_s2 <= band_s1;
			num_s3 <= pa_s2 + pb_s2 + NW'(span_s2 >> 1);
			span_s3 <= span_s2; d_s3 <= d_s2; a_s3 <= a_s2; band_s3 <= band_s2;
		end
	end

	always_comb begin
		rem_q[0] = num_s3; quo_q[0] = '0; span_q[0] = span_s3;
		dd_q[0] = d_s3; aa_q[0] = a_s3; bb_q[0] = band_s3;
	end

	// quotient fits in 17 bits since it lies between two 16 bit factors
	for (genvar g = 0; g < DStages; g++) begin : g_div
		logic [NW-1:0] r;
		logic [QW-1:0] q;
		always_comb begin
			r = rem_q[g]; q = quo_q[g];
			for (int k = 0; k < BitsPer; k++) begin
				int bi;
				logic [NW-1:0] t;
				bi = QW - 1 - (g * BitsPer + k);
				if (bi >= 0) begin
					t = NW'(span_q[g]) << bi;
					if ((r >> bi) >= NW'(span_q[g])) begin
						r = r - t;
						q[bi] = 1'b1;
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1] <= r; quo_q[g+1] <= q; span_q[g+1] <= span_q[g];
				dd_q[g+1] <= dd_q[g]; aa_q[g+1] <= aa_q[g]; bb_q[g+1] <= bb_q[g];
			end
		end
	end

	assign level = (bb_q[DStages] == lod_pkg::BandNear || bb_q[DStages] == lod_pkg::BandBeyond)
		? aa_q[DStages] : quo_q[DStages][lod_pkg::FactW-1:0];
	assign dist_out = dd_q[DStages];
	assign band = bb_q[DStages];
endmodule

@@ src/lod_detail_interpolator.sv @@
// lod detail interpolator: input register, distance unit and interpolation unit, then an output register
// throughput one item per cycle while the skid register is empty; the distance root and the interpolation divider
// are both fully pipelined, a stall on m_axis that fills the skid register freezes all stages together
// a one-entry output skid keeps s_axis_tready high while a result waits
// arst_n clears valid bits and resets the level table to its defaults
// depends on lod_pkg, lod_dist, lod_lerp and the defines header
`include "lod_detail_interpolator_defines.svh"
module lod_detail_interpolator #(
	parameter int COORD_WIDTH = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// obj_x, obj_y, obj_z, cam_x, cam_y, cam_z
	input  logic [6*COORD_WIDTH-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// detail_level, distance_out, band, zero fill
	output logic [47:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int Lat = 1 + 3 + lod_pkg::RootStages + 3 + 4;
	lod_pkg::cfg_t cfg_q;
	logic [Lat-1:0] vld_q;
	logic en;
	logic [COORD_WIDTH-1:0] ax [3];
	logic [COORD_WIDTH-1:0] bx [3];
	logic [COORD_WIDTH-1:0] in_q [6];
	logic [lod_pkg::DistW-1:0] dist_val, dist_out;
	logic [lod_pkg::FactW-1:0] level;
	logic [1:0] band;
	logic skid_vld_q, out_vld_q;
	logic [41:0] skid_q, out_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{24'd2560, 16'd32768, 24'd12800, 16'd22938, 24'd25600, 16'd9830};
		end else if (cfg_valid) begin
			case (cfg_index)
				lod_pkg::RegNearThr: cfg_q.near_thr <= cfg_data[23:0];
				lod_pkg::RegNearFac: cfg_q.near_fac <= cfg_data[15:0];
				lod_pkg::RegMidThr: cfg_q.mid_thr <= cfg_data[23:0];
				lod_pkg::RegMidFac: cfg_q.mid_fac <= cfg_data[15:0];
				lod_pkg::RegFarThr: cfg_q.far_thr <= cfg_data[23:0];
				lod_pkg::RegFarFac: cfg_q.far_fac <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// pipeline advances unless the skid register is full
	assign en = !skid_vld_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 6; i++) in_q[i] <= s_axis_tdata[i*COORD_WIDTH +: COORD_WIDTH];
		end
	end
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[i] = in_q[i];
			bx[i] = in_q[i+3];
		end
	end

	lod_dist #(.COORD_WIDTH(COORD_WIDTH)) u_dist (
		.clk, .en, .ax, .bx, .dist_val
	);
	lod_lerp u_lerp (
		.clk, .en, .cfg(cfg_q), .dist_val, .level, .dist_out, .band
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
			if (!out_vld_q || m_axis_tready) begin
				out_vld_q <= skid_vld_q || (en && vld_q[Lat-1]);
				skid_vld_q <= 1'b0;
			end else if (en && vld_q[Lat-1]) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			out_q <= skid_vld_q ? skid_q : {band, dist_out, level};
		end else if (en && vld_q[Lat-1]) begin
			skid_q <= {band, dist_out, level};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {6'd0, out_q};

	`LOD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`LOD_ASSERT_IMP(a_skid, skid_vld_q, out_vld_q, "skid full with empty output")
	`LOD_ASSERT_NEXT(a_skid_stall, skid_vld_q && !m_axis_tready, !s_axis_tready,
		"input accepted with skid full")
endmodule
